>>> design/fl64_pkg.sv
// Package for the Fletcher-64 block verifier: widths, word position codes,
// the snapshot struct passed from accumulation to folding, and mod 2^32-1 helpers.
// No dependencies.
package fl64_pkg;

  localparam int WORD_W = 32;
  localparam int CSUM_W = 2 * WORD_W;

  localparam logic [WORD_W-1:0] MOD32M1 = 32'hFFFF_FFFF;

  // Words seen in the current block, saturating at two
  typedef enum logic [1:0] {
    POS_ZERO = 2'd0,
    POS_ONE  = 2'd1,
    POS_TWO  = 2'd2
  } fl64_pos_t;

  // Block state captured at the last word, handed to the fold pipeline
  typedef struct packed {
    logic [WORD_W-1:0] first_sum;
    logic [WORD_W-1:0] second_sum;
    logic [WORD_W-1:0] held_word_zero;
    logic [WORD_W-1:0] held_word_one;
    logic              short_block;
  } fl64_snap_t;

  // All-ones is congruent to zero modulo 2^32-1
  function automatic logic [WORD_W-1:0] reduce_word(input logic [WORD_W-1:0] w);
    return (w == MOD32M1) ? '0 : w;
  endfunction

  // (a + b) mod 2^32-1, both operands already reduced
  function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [WORD_W:0] sum;
    logic [WORD_W:0] adj;
    sum = {1'b0, a} + {1'b0, b};
    adj = sum - {1'b0, MOD32M1};
    return (sum >= {1'b0, MOD32M1}) ? adj[WORD_W-1:0] : sum[WORD_W-1:0];
  endfunction

endpackage

>>> design/fl64_if.sv
// Channel interfaces for the Fletcher-64 verifier: block words in, results out.
// Valid/ready handshake; depends on fl64_pkg.
interface fl64_in_if;
  import fl64_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

interface fl64_out_if;
  import fl64_pkg::*;

  logic              valid;
  logic              ready;
  logic [CSUM_W-1:0] checksum;
  logic              block_ok;
  logic              short_block;

  modport source (output valid, output checksum, output block_ok, output short_block,
                  input ready);
  modport sink   (input valid, input checksum, input block_ok, input short_block,
                  output ready);
endinterface

>>> design/fl64_accum.sv
// Input register and running Fletcher sum pair for the block verifier.
// Emits a snapshot of the block state on its last word; depends on fl64_pkg, fl64_if.
module fl64_accum (
  input  logic                clk,
  input  logic                rst_n,
  fl64_in_if.sink             in_chan,
  output logic                snap_valid,
  input  logic                snap_ready,
  output fl64_pkg::fl64_snap_t snap
);
  import fl64_pkg::*;

  logic              v0_r;
  logic [WORD_W-1:0] word0_r;
  logic              last0_r;

  logic [WORD_W-1:0] first_r, first_nxt;
  logic [WORD_W-1:0] second_r, second_nxt;
  logic [WORD_W-1:0] held0_r, held0_nxt;
  logic [WORD_W-1:0] held1_r, held1_nxt;
  fl64_pos_t         pos_r, pos_nxt;

  logic consume;

  // Item in the input register leaves when it is not a last word or the fold side takes it
  assign consume      = v0_r && (!last0_r || snap_ready);
  assign in_chan.ready = !v0_r || consume;
  assign snap_valid   = v0_r && last0_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_chan.ready) begin
      v0_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      word0_r <= in_chan.word;
      last0_r <= in_chan.last;
    end
  end

  // Block state after this word: hold the two stored words, then accumulate
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    held0_nxt  = held0_r;
    held1_nxt  = held1_r;
    pos_nxt    = pos_r;
    case (pos_r)
      POS_ZERO: begin
        held0_nxt = word0_r;
        pos_nxt   = POS_ONE;
      end
      POS_ONE: begin
        held1_nxt = word0_r;
        pos_nxt   = POS_TWO;
      end
      default: begin
        first_nxt  = add_mod(first_r, reduce_word(word0_r));
        second_nxt = add_mod(second_r, first_nxt);
      end
    endcase
  end

  assign snap.first_sum      = first_nxt;
  assign snap.second_sum     = second_nxt;
  assign snap.held_word_zero = held0_nxt;
  assign snap.held_word_one  = held1_nxt;
  assign snap.short_block    = (pos_r == POS_ZERO);

  // State registers; a last word clears everything for the next block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      held0_r  <= '0;
      held1_r  <= '0;
      pos_r    <= POS_ZERO;
    end else if (consume) begin
      if (last0_r) begin
        first_r  <= '0;
        second_r <= '0;
        held0_r  <= '0;
        held1_r  <= '0;
        pos_r    <= POS_ZERO;
      end else begin
        first_r  <= first_nxt;
        second_r <= second_nxt;
        held0_r  <= held0_nxt;
        held1_r  <= held1_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  // Running sums stay reduced
  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    first_r != MOD32M1 && second_r != MOD32M1)
    else $error("running sum left unreduced");

  // A consumed last word returns the block to its start
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    consume && last0_r |=> pos_r == POS_ZERO && first_r == '0 && second_r == '0)
    else $error("block state not cleared after last word");

  // Sums only move once both stored words are held
  a_sums_wait: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != POS_TWO |-> first_r == '0 && second_r == '0)
    else $error("sum changed before third word");
`endif

endmodule

>>> design/fl64_fold.sv
// Fold pipeline: adds the two stored checksum words into the sum pair over two
// stages and holds the result in the output register; depends on fl64_pkg, fl64_if.
module fl64_fold (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 snap_valid,
  output logic                 snap_ready,
  input  fl64_pkg::fl64_snap_t snap,
  fl64_out_if.source           out_chan
);
  import fl64_pkg::*;

  logic       va_r;
  fl64_snap_t snap_a_r;

  logic              vb_r;
  logic [WORD_W-1:0] f1_b_r, s1_b_r, held1_b_r;
  logic              short_b_r;

  logic              vc_r;
  logic [CSUM_W-1:0] csum_c_r;
  logic              ok_c_r;
  logic              short_c_r;

  logic              a_ready, b_ready, c_ready;
  logic [WORD_W-1:0] f1_nxt, s1_nxt, f2_nxt, s2_nxt;
  logic [CSUM_W-1:0] csum_nxt;

  // Each stage moves when it is empty or the one after it moves
  assign c_ready    = !vc_r || out_chan.ready;
  assign b_ready    = !vb_r || c_ready;
  assign a_ready    = !va_r || b_ready;
  assign snap_ready = a_ready;

  // First fold: stored word zero
  assign f1_nxt = add_mod(snap_a_r.first_sum, reduce_word(snap_a_r.held_word_zero));
  assign s1_nxt = add_mod(snap_a_r.second_sum, f1_nxt);

  // Second fold: stored word one
  assign f2_nxt   = add_mod(f1_b_r, reduce_word(held1_b_r));
  assign s2_nxt   = add_mod(s1_b_r, f2_nxt);
  assign csum_nxt = short_b_r ? '0 : {s2_nxt, f2_nxt};

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (a_ready) begin
        va_r <= snap_valid;
      end
      if (b_ready) begin
        vb_r <= va_r;
      end
      if (c_ready) begin
        vc_r <= vb_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (a_ready && snap_valid) begin
      snap_a_r <= snap;
    end
    if (b_ready && va_r) begin
      f1_b_r    <= f1_nxt;
      s1_b_r    <= s1_nxt;
      held1_b_r <= snap_a_r.held_word_one;
      short_b_r <= snap_a_r.short_block;
    end
    if (c_ready && vb_r) begin
      csum_c_r  <= csum_nxt;
      ok_c_r    <= !short_b_r && (csum_nxt == '0);
      short_c_r <= short_b_r;
    end
  end

  assign out_chan.valid       = vc_r;
  assign out_chan.checksum    = csum_c_r;
  assign out_chan.block_ok    = ok_c_r;
  assign out_chan.short_block = short_c_r;

`ifndef ASSERT_OFF
  // Both halves of a reported checksum are reduced
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |-> csum_c_r[WORD_W-1:0] != MOD32M1 && csum_c_r[CSUM_W-1:WORD_W] != MOD32M1)
    else $error("reported checksum half not reduced");

  // A short block never verifies and reports a zero checksum
  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && short_c_r |-> !ok_c_r && csum_c_r == '0)
    else $error("short block result malformed");

  // An item in stage B reaches the output register on the next edge when it is free
  a_b_to_c: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && c_ready |=> vc_r)
    else $error("item lost between fold stages");
`endif

endmodule

>>> design/block_fletcher64_verify.sv
// Fletcher-64 block verifier, top level.
// Channels: in_chan (sink) takes one 32-bit little-endian block word per item,
// with last set on the block's final word. out_chan (source) gives one result
// item per block: checksum (second sum high, first sum low, both mod 2^32-1),
// block_ok when the checksum is zero and the block is not short, short_block for a one-word block.
// The first two words of a block are the stored checksum and are held aside;
// later words update the running sum pair.
// Throughput: one word per cycle, set by the two end-around-carry adds of the
// running sum pair in fl64_accum, except while a last word waits for the fold side.
// Path of a last word: the input register captures it at the edge that accepts it;
// two fold stages in fl64_fold follow, then the output register, which drives
// out_chan.valid.
// Reset (rst_n low, synchronous) empties all stages and clears the sum pair,
// held words and word position, so the next word starts a new block.
// When out_chan stalls, non-last words keep being accepted; last words fill the
// fold stages, and in_chan.ready drops only when a last word cannot move on.
// Depends on fl64_pkg, fl64_if, fl64_accum, fl64_fold.
module block_fletcher64_verify (
  input  logic       clk,
  input  logic       rst_n,
  fl64_in_if.sink    in_chan,
  fl64_out_if.source out_chan
);
  import fl64_pkg::*;

  logic       snap_valid;
  logic       snap_ready;
  fl64_snap_t snap;

  fl64_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  fl64_fold u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_chan   (out_chan)
  );

endmodule
